// ===== src/psp_pkg.sv =====
// Shared types, register indexes and the quarter-wave sine table for the point transform.
`default_nettype none

package psp_pkg;

   // Fixed widths of the configuration and result fields
   localparam int ModeBits  = 2;
   localparam int AngleBits = 9;
   localparam int ScaleBits = 16;
   localparam int OutBits   = 16;
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 16;

   // Operating modes; the unused code behaves as translate only
   typedef enum logic [ModeBits-1:0] {
      MODE_SHIFT  = 2'd0,
      MODE_ROTATE = 2'd1,
      MODE_SCALE  = 2'd2
   } mode_type;

   // Configuration register indexes
   localparam logic [CsrIndexBits-1:0] REG_MODE    = 3'd0;
   localparam logic [CsrIndexBits-1:0] REG_PIVOT_X = 3'd1;
   localparam logic [CsrIndexBits-1:0] REG_PIVOT_Y = 3'd2;
   localparam logic [CsrIndexBits-1:0] REG_SHIFT_X = 3'd3;
   localparam logic [CsrIndexBits-1:0] REG_SHIFT_Y = 3'd4;
   localparam logic [CsrIndexBits-1:0] REG_ANGLE   = 3'd5;
   localparam logic [CsrIndexBits-1:0] REG_SCALE   = 3'd6;

   // Angle folding
   localparam int FullTurn   = 360;
   localparam int QuarterTurn = 90;

   // round(sin(d degrees) * 65536) for d = 0..90
   localparam int SinEntries = 91;
   localparam logic [16:0] SIN16 [0:SinEntries-1] = '{
      17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
      17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
      17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
      17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
      17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
      17'd37590, 17'd38521, 17'd39440, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
      17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
      17'd49461, 17'd50204, 17'd50931, 17'd51643, 17'd52340, 17'd53020, 17'd53684,
      17'd54332, 17'd54963, 17'd55578, 17'd56176, 17'd56756, 17'd57319, 17'd57865,
      17'd58393, 17'd58904, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
      17'd61584, 17'd61966, 17'd62329, 17'd62673, 17'd62997, 17'd63303, 17'd63590,
      17'd63857, 17'd64104, 17'd64332, 17'd64541, 17'd64729, 17'd64898, 17'd65048,
      17'd65177, 17'd65287, 17'd65377, 17'd65446, 17'd65496, 17'd65526, 17'd65536
   };

endpackage

`default_nettype wire

// ===== src/point_rotate_scale_pivot.sv =====
// Throughput: one point per cycle while the receiver does not stall; the transform
// is a single pass between the input register and the result register, with the
// four rotation products in parallel.
// Reset: synchronous, clears both valid flags and loads the configuration reset
// values; there is no memory and no clearing pass.
`default_nettype none

module point_rotate_scale_pivot
   import psp_pkg::*;
#(
   parameter int COORD_BITS     = 12,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Configuration write port
   input  wire logic                         csr_wr_en,
   input  wire logic [CsrIndexBits-1:0]      csr_index,
   input  wire logic [CsrDataBits-1:0]       csr_wdata,
   // Input channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   // Result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [OutBits-1:0]         rsp_out_x,
   output logic signed [OutBits-1:0]         rsp_out_y,
   output logic                              rsp_clipped
);

   localparam int CB = COORD_BITS;

   logic [ModeBits-1:0]  mode_ff;
   logic signed [CB-1:0] pivot_x_ff;
   logic signed [CB-1:0] pivot_y_ff;
   logic signed [CB-1:0] shift_x_ff;
   logic signed [CB-1:0] shift_y_ff;
   logic [AngleBits-1:0] angle_ff;
   logic [ScaleBits-1:0] scale_ff;

   logic                 in_valid_ff;
   logic signed [CB-1:0] in_x_ff;
   logic signed [CB-1:0] in_y_ff;

   logic                      out_valid_ff;
   logic signed [OutBits-1:0] out_x_ff;
   logic signed [OutBits-1:0] out_y_ff;
   logic                      out_clip_ff;

   logic signed [OutBits-1:0] out_x_in;
   logic signed [OutBits-1:0] out_y_in;
   logic                      out_clip_in;

   logic out_free;
   logic in_free;
   logic req_take;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SHIFT;
         pivot_x_ff <= CB'(200);
         pivot_y_ff <= CB'(100);
         shift_x_ff <= CB'(50);
         shift_y_ff <= CB'(0);
         angle_ff   <= AngleBits'(0);
         scale_ff   <= ScaleBits'(256);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MODE:    mode_ff    <= csr_wdata[ModeBits-1:0];
            REG_PIVOT_X: pivot_x_ff <= csr_wdata[CB-1:0];
            REG_PIVOT_Y: pivot_y_ff <= csr_wdata[CB-1:0];
            REG_SHIFT_X: shift_x_ff <= csr_wdata[CB-1:0];
            REG_SHIFT_Y: shift_y_ff <= csr_wdata[CB-1:0];
            REG_ANGLE:   angle_ff   <= csr_wdata[AngleBits-1:0];
            REG_SCALE:   scale_ff   <= csr_wdata[ScaleBits-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: each register moves on when the stage after it can take it
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_free   = !in_valid_ff || out_free;
   assign req_stall = !in_free;
   assign req_take  = req_valid && in_free;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_x_ff <= req_point_x;
         in_y_ff <= req_point_y;
      end
   end

   psp_datapath #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_datapath (
      .point_x   (in_x_ff),
      .point_y   (in_y_ff),
      .mode      (mode_ff),
      .pivot_x   (pivot_x_ff),
      .pivot_y   (pivot_y_ff),
      .shift_x   (shift_x_ff),
      .shift_y   (shift_y_ff),
      .angle_deg (angle_ff),
      .scale_q8  (scale_ff),
      .out_x     (out_x_in),
      .out_y     (out_y_in),
      .clipped   (out_clip_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && in_valid_ff) begin
         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
         out_clip_ff <= out_clip_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_out_x   = out_x_ff;
   assign rsp_out_y   = out_y_ff;
   assign rsp_clipped = out_clip_ff;

endmodule

`default_nettype wire

// ===== src/psp_trig.sv =====
// Sine and cosine of a whole-degree angle from the quarter-wave table.
`default_nettype none

module psp_trig
   import psp_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic [AngleBits-1:0]      angle_deg,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

   localparam int TW    = TRIG_FRAC_BITS + 2;
   localparam int Shift = 16 - TRIG_FRAC_BITS;
   localparam logic [17:0] Half = 18'((1 << Shift) >> 1);

   logic [AngleBits-1:0] ang;
   logic [6:0]           s_idx;
   logic [6:0]           c_idx;
   logic                 s_neg;
   logic                 c_neg;
   logic [17:0]          s_round;
   logic [17:0]          c_round;
   logic signed [TW-1:0] s_mag;
   logic signed [TW-1:0] c_mag;

   // Fold the angle into one turn, then into the first quadrant
   always_comb begin
      if (angle_deg >= AngleBits'(FullTurn)) begin
         ang = angle_deg - AngleBits'(FullTurn);
      end else begin
         ang = angle_deg;
      end
      if (ang <= AngleBits'(QuarterTurn)) begin
         s_idx = 7'(ang);
         c_idx = 7'(AngleBits'(QuarterTurn) - ang);
         s_neg = 1'b0;
         c_neg = 1'b0;
      end else if (ang <= AngleBits'(2 * QuarterTurn)) begin
         s_idx = 7'(AngleBits'(2 * QuarterTurn) - ang);
         c_idx = 7'(ang - AngleBits'(QuarterTurn));
         s_neg = 1'b0;
         c_neg = 1'b1;
      end else if (ang <= AngleBits'(3 * QuarterTurn)) begin
         s_idx = 7'(ang - AngleBits'(2 * QuarterTurn));
         c_idx = 7'(AngleBits'(3 * QuarterTurn) - ang);
         s_neg = 1'b1;
         c_neg = 1'b1;
      end else begin
         s_idx = 7'(AngleBits'(FullTurn) - ang);
         c_idx = 7'(ang - AngleBits'(3 * QuarterTurn));
         s_neg = 1'b1;
         c_neg = 1'b0;
      end
   end

   // Round the 17-bit table entries to the working fraction width, half up
   always_comb begin
      s_round = (18'(SIN16[s_idx]) + Half) >> Shift;
      c_round = (18'(SIN16[c_idx]) + Half) >> Shift;
      s_mag   = signed'(TW'(s_round[TRIG_FRAC_BITS:0]));
      c_mag   = signed'(TW'(c_round[TRIG_FRAC_BITS:0]));
      sin_val = s_neg ? -s_mag : s_mag;
      cos_val = c_neg ? -c_mag : c_mag;
   end

endmodule

`default_nettype wire

// ===== src/psp_datapath.sv =====
// Combinational transform of one shifted point: translate, rotate or scale, then saturate.
`default_nettype none

module psp_datapath
   import psp_pkg::*;
#(
   parameter int COORD_BITS     = 12,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic signed [COORD_BITS-1:0] point_x,
   input  wire logic signed [COORD_BITS-1:0] point_y,
   input  wire logic [ModeBits-1:0]          mode,
   input  wire logic signed [COORD_BITS-1:0] pivot_x,
   input  wire logic signed [COORD_BITS-1:0] pivot_y,
   input  wire logic signed [COORD_BITS-1:0] shift_x,
   input  wire logic signed [COORD_BITS-1:0] shift_y,
   input  wire logic [AngleBits-1:0]         angle_deg,
   input  wire logic [ScaleBits-1:0]         scale_q8,
   output logic signed [OutBits-1:0]         out_x,
   output logic signed [OutBits-1:0]         out_y,
   output logic                              clipped
);

   localparam int CB = COORD_BITS;
   localparam int F  = TRIG_FRAC_BITS;
   localparam int TW = F + 2;
   localparam int DW = CB + 2;            // pivot-relative coordinate
   localparam int PW = DW + TW;           // rotation product
   localparam int SW = PW + 2;            // rotation sum
   localparam int QW = SW - F;            // rotation quotient
   localparam int KW = ScaleBits + 1;     // scale factor as a signed value
   localparam int MW = DW + KW;           // scale product
   localparam int RW = (CB + 12 > OutBits + 1) ? CB + 12 : OutBits + 1;
   localparam logic signed [RW-1:0] MaxOut = RW'(32767);
   localparam logic signed [RW-1:0] MinOut = RW'(-32768);

   logic signed [CB:0]   sx;
   logic signed [CB:0]   sy;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;
   logic signed [TW-1:0] sin_val;
   logic signed [TW-1:0] cos_val;

   logic signed [PW-1:0] p_xc;
   logic signed [PW-1:0] p_ys;
   logic signed [PW-1:0] p_xs;
   logic signed [PW-1:0] p_yc;
   logic signed [SW-1:0] rot_x_sum;
   logic signed [SW-1:0] rot_y_sum;
   logic signed [SW-1:0] rot_x_adj;
   logic signed [SW-1:0] rot_y_adj;
   logic signed [QW-1:0] rot_x;
   logic signed [QW-1:0] rot_y;

   logic signed [KW-1:0] k_val;
   logic signed [MW-1:0] m_x;
   logic signed [MW-1:0] m_y;
   logic signed [MW-1:0] m_x_adj;
   logic signed [MW-1:0] m_y_adj;

   logic signed [RW-1:0] res_x;
   logic signed [RW-1:0] res_y;
   logic                 clip_x;
   logic                 clip_y;

   psp_trig #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_trig (
      .angle_deg (angle_deg),
      .sin_val   (sin_val),
      .cos_val   (cos_val)
   );

   // Shift the point and take it relative to the pivot
   always_comb begin
      sx = (CB+1)'(point_x) + (CB+1)'(shift_x);
      sy = (CB+1)'(point_y) + (CB+1)'(shift_y);
      dx = DW'(sx) - DW'(pivot_x);
      dy = DW'(sy) - DW'(pivot_y);
   end

   // Rotation: four products, pivot added back, divided by 2^F toward zero
   always_comb begin
      p_xc = PW'(dx) * PW'(cos_val);
      p_ys = PW'(dy) * PW'(sin_val);
      p_xs = PW'(dx) * PW'(sin_val);
      p_yc = PW'(dy) * PW'(cos_val);
      rot_x_sum = SW'(p_xc) - SW'(p_ys) + (SW'(pivot_x) <<< F);
      rot_y_sum = SW'(p_xs) + SW'(p_yc) + (SW'(pivot_y) <<< F);
      rot_x_adj = rot_x_sum + signed'(SW'({F{rot_x_sum[SW-1]}}));
      rot_y_adj = rot_y_sum + signed'(SW'({F{rot_y_sum[SW-1]}}));
      rot_x = rot_x_adj[SW-1:F];
      rot_y = rot_y_adj[SW-1:F];
   end

   // Scaling: Q8.8 product divided by 256 toward zero
   always_comb begin
      k_val   = signed'({1'b0, scale_q8});
      m_x     = MW'(dx) * MW'(k_val);
      m_y     = MW'(dy) * MW'(k_val);
      m_x_adj = m_x + signed'(MW'({8{m_x[MW-1]}}));
      m_y_adj = m_y + signed'(MW'({8{m_y[MW-1]}}));
   end

   // Mode selection
   always_comb begin
      case (mode)
         MODE_ROTATE: begin
            res_x = RW'(rot_x);
            res_y = RW'(rot_y);
         end
         MODE_SCALE: begin
            res_x = RW'(signed'(m_x_adj[MW-1:8])) + RW'(pivot_x);
            res_y = RW'(signed'(m_y_adj[MW-1:8])) + RW'(pivot_y);
         end
         default: begin
            res_x = RW'(sx);
            res_y = RW'(sy);
         end
      endcase
   end

   // Saturate each coordinate to the 16-bit result range
   always_comb begin
      clip_x = 1'b0;
      clip_y = 1'b0;
      if (res_x > MaxOut) begin
         out_x  = OutBits'(MaxOut);
         clip_x = 1'b1;
      end else if (res_x < MinOut) begin
         out_x  = OutBits'(MinOut);
         clip_x = 1'b1;
      end else begin
         out_x  = res_x[OutBits-1:0];
      end
      if (res_y > MaxOut) begin
         out_y  = OutBits'(MaxOut);
         clip_y = 1'b1;
      end else if (res_y < MinOut) begin
         out_y  = OutBits'(MinOut);
         clip_y = 1'b1;
      end else begin
         out_y  = res_y[OutBits-1:0];
      end
      clipped = clip_x | clip_y;
   end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the 2D point translate, rotate and scale block.
`timescale 1ns / 100ps

module tb_top;
   import psp_pkg::*;

   localparam int CoordBits = 12;
   localparam int TrigFrac  = 14;
   localparam int CoordMin  = -(1 << (CoordBits - 1));
   localparam int CoordMax  = (1 << (CoordBits - 1)) - 1;
   localparam int OutMin    = -(1 << (OutBits - 1));
   localparam int OutMax    = (1 << (OutBits - 1)) - 1;
   localparam int SineDrop  = 16 - TrigFrac;
   localparam int SineRound = (1 << SineDrop) >> 1;
   localparam int ScaleOne  = 256;
   // The slowest legal stretch without a transfer is the receiver hold-off
   // plus a few long random gaps; this limit allows for that many times over.
   localparam int QuietLimit = 2000;
   localparam int ReportCap  = 40;

   // Register index past the end of the list, and the mode code with no enum member
   localparam logic [CsrIndexBits-1:0] REG_SPARE   = 3'd7;
   localparam logic [ModeBits-1:0]     MODE_UNUSED = 2'd3;

   // round(sin(d degrees) * 65536) for d = 0..90
   localparam int QuarterSine [0:90] = '{
      0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
      11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
      22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
      32768, 33754, 34729, 35693, 36647, 37590, 38521, 39440, 40348, 41243,
      42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
      50204, 50931, 51643, 52340, 53020, 53684, 54332, 54963, 55578, 56176,
      56756, 57319, 57865, 58393, 58904, 59396, 59870, 60326, 60764, 61183,
      61584, 61966, 62329, 62673, 62997, 63303, 63590, 63857, 64104, 64332,
      64541, 64729, 64898, 65048, 65177, 65287, 65377, 65446, 65496, 65526,
      65536
   };

   typedef logic signed [CoordBits-1:0] coord_t;

   typedef struct packed {
      logic signed [OutBits-1:0] x;
      logic signed [OutBits-1:0] y;
      logic                      clipped;
   } point_result_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CsrIndexBits-1:0]   csr_index = '0;
   logic [CsrDataBits-1:0]    csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   coord_t                    req_point_x = '0;
   coord_t                    req_point_y = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [OutBits-1:0] rsp_out_x;
   logic signed [OutBits-1:0] rsp_out_y;
   logic                      rsp_clipped;

   // Testbench copy of the configuration registers, at their reset values
   logic [ModeBits-1:0]  cfg_mode    = MODE_SHIFT;
   coord_t               cfg_pivot_x = 200;
   coord_t               cfg_pivot_y = 100;
   coord_t               cfg_shift_x = 50;
   coord_t               cfg_shift_y = 0;
   logic [AngleBits-1:0] cfg_angle   = '0;
   logic [ScaleBits-1:0] cfg_scale   = 16'd256;

   point_result_t expected_points [$];
   int            sender_gap_pct     = 0;
   int            receiver_stall_pct = 0;
   int            hold_off_cycles    = 0;
   int            quiet_cycles       = 0;
   int            mismatches         = 0;
   int            points_sent        = 0;
   int            results_checked    = 0;
   int            clipped_results    = 0;
   int            reg_writes         = 0;

   point_rotate_scale_pivot #(
      .COORD_BITS     (CoordBits),
      .TRIG_FRAC_BITS (TrigFrac)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_clipped (rsp_clipped)
   );

   // 20 ns clock.
   initial begin
      forever #10 clock = ~clock;
   end

   // Sine of a whole angle in the first quadrant, rounded to the trig fraction width.
   function automatic longint quarter_sine_q(int deg);
      return longint'((QuarterSine[deg] + SineRound) >> SineDrop);
   endfunction

   // Saturate to the result width and note any clipping.
   function automatic logic signed [OutBits-1:0] clamp_out(longint v, inout logic clip);
      if (v > OutMax) begin
         clip = 1'b1;
         return OutBits'(OutMax);
      end
      if (v < OutMin) begin
         clip = 1'b1;
         return OutBits'(OutMin);
      end
      return OutBits'(v);
   endfunction

   // Expected result of one point under the current configuration.
   function automatic point_result_t transform_point(coord_t in_x, coord_t in_y);
      longint        sx, sy, px, py, dx, dy, rx, ry, s, c, unit_q;
      int            a;
      logic          clip;
      point_result_t r;
      sx = longint'(in_x) + longint'(cfg_shift_x);
      sy = longint'(in_y) + longint'(cfg_shift_y);
      px = longint'(cfg_pivot_x);
      py = longint'(cfg_pivot_y);
      dx = sx - px;
      dy = sy - py;
      rx = sx;
      ry = sy;
      clip = 1'b0;
      if (cfg_mode == MODE_ROTATE) begin
         a = int'(cfg_angle);
         if (a >= FullTurn) a -= FullTurn;
         // Fold the angle into the first quadrant and restore the signs.
         if (a <= QuarterTurn) begin
            s = quarter_sine_q(a);
            c = quarter_sine_q(QuarterTurn - a);
         end else if (a <= 2 * QuarterTurn) begin
            s = quarter_sine_q(2 * QuarterTurn - a);
            c = -quarter_sine_q(a - QuarterTurn);
         end else if (a <= 3 * QuarterTurn) begin
            s = -quarter_sine_q(a - 2 * QuarterTurn);
            c = -quarter_sine_q(3 * QuarterTurn - a);
         end else begin
            s = -quarter_sine_q(FullTurn - a);
            c = quarter_sine_q(a - 3 * QuarterTurn);
         end
         unit_q = longint'(1) << TrigFrac;
         // Division on signed integers truncates toward zero.
         rx = (dx * c - dy * s + px * unit_q) / unit_q;
         ry = (dx * s + dy * c + py * unit_q) / unit_q;
      end else if (cfg_mode == MODE_SCALE) begin
         rx = (dx * longint'(cfg_scale)) / ScaleOne + px;
         ry = (dy * longint'(cfg_scale)) / ScaleOne + py;
      end
      r.x = clamp_out(rx, clip);
      r.y = clamp_out(ry, clip);
      r.clipped = clip;
      return r;
   endfunction

   // Compare one result field and report a mismatch.
   task automatic check_field(string field, int want, int got);
      if (want != got) begin
         if (mismatches < ReportCap)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Predict each accepted point and check each accepted result against the oldest
   // prediction.
   always @(posedge clock) begin
      point_result_t want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_points.push_back(transform_point(req_point_x, req_point_y));
            points_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               if (mismatches < ReportCap)
                  $display("%0t: unexpected result transfer, actual x %0d y %0d clipped %0d",
                           $time, rsp_out_x, rsp_out_y, rsp_clipped);
               mismatches++;
            end else begin
               want = expected_points.pop_front();
               check_field("out_x", $signed(want.x), rsp_out_x);
               check_field("out_y", $signed(want.y), rsp_out_y);
               check_field("clipped", want.clipped, rsp_clipped);
               results_checked++;
               if (want.clipped) clipped_results++;
            end
         end
      end
   end

   // Receiver: a counted hold-off when one is requested, otherwise random stalls.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, QuietLimit, expected_points.size());
         $display("point_rotate_scale_pivot verification failed");
         $finish;
      end
   end

   // Offer one point after an optional random gap and wait for its transfer.
   task automatic send_point(coord_t x, coord_t y);
      while ($urandom_range(99) < sender_gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every expected result has arrived.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; the local copy keeps only the register's width.
   task automatic write_reg(logic [CsrIndexBits-1:0] index, logic [CsrDataBits-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      reg_writes++;
      case (index)
         REG_MODE:    cfg_mode    = data[ModeBits-1:0];
         REG_PIVOT_X: cfg_pivot_x = data[CoordBits-1:0];
         REG_PIVOT_Y: cfg_pivot_y = data[CoordBits-1:0];
         REG_SHIFT_X: cfg_shift_x = data[CoordBits-1:0];
         REG_SHIFT_Y: cfg_shift_y = data[CoordBits-1:0];
         REG_ANGLE:   cfg_angle   = data[AngleBits-1:0];
         REG_SCALE:   cfg_scale   = data[ScaleBits-1:0];
         default: ;
      endcase
   endtask

   // Random coordinate with the range ends favoured.
   function automatic coord_t random_coord();
      case ($urandom_range(7))
         0: return coord_t'(CoordMin);
         1: return coord_t'(CoordMax);
         default: return coord_t'($urandom);
      endcase
   endfunction

   // Points through the reset configuration: translate by the reset shift.
   task automatic test_reset_values();
      send_point(0, 0);
      send_point(coord_t'(CoordMax), coord_t'(CoordMax));
      send_point(coord_t'(CoordMin), coord_t'(CoordMin));
      wait_idle();
   endtask

   // Translate with extreme shifts; upper data bits must be dropped, and the unused mode
   // code behaves as translate.
   task automatic test_translate();
      write_reg(REG_MODE, {14'h3FFF, MODE_SHIFT});
      write_reg(REG_SHIFT_X, 16'hF7FF);
      write_reg(REG_SHIFT_Y, 16'h0800);
      send_point(coord_t'(CoordMax), coord_t'(CoordMin));
      send_point(coord_t'(CoordMin), coord_t'(CoordMax));
      wait_idle();
      write_reg(REG_MODE, {14'd0, MODE_UNUSED});
      send_point(5, -7);
      wait_idle();
   endtask

   // A write past the register list changes nothing.
   task automatic test_spare_index();
      write_reg(REG_SPARE, 16'hFFFF);
      send_point(-1, 1);
      wait_idle();
   endtask

   // Rotation about a corner pivot at every quadrant edge and at folded angles.
   task automatic test_rotate();
      int angles [7];
      angles = '{90, 180, 270, 359, 360, 511, 45};
      write_reg(REG_MODE, {14'd0, MODE_ROTATE});
      write_reg(REG_PIVOT_X, 16'(CoordMin));
      write_reg(REG_PIVOT_Y, 16'(CoordMax));
      write_reg(REG_SHIFT_X, 16'd0);
      write_reg(REG_SHIFT_Y, 16'd0);
      foreach (angles[i]) begin
         write_reg(REG_ANGLE, 16'(angles[i]));
         send_point(coord_t'(i[0] ? CoordMax : -3), coord_t'(i[0] ? CoordMin : 1000));
         wait_idle();
      end
   endtask

   // Scaling at the largest factor (saturating both ways), zero, and just under one.
   task automatic test_scale();
      write_reg(REG_MODE, {14'd0, MODE_SCALE});
      write_reg(REG_SHIFT_X, 16'(CoordMax));
      write_reg(REG_SHIFT_Y, 16'(CoordMin));
      write_reg(REG_SCALE, 16'hFFFF);
      send_point(coord_t'(CoordMax), coord_t'(CoordMin));
      wait_idle();
      write_reg(REG_SCALE, 16'd0);
      send_point(100, -100);
      wait_idle();
      write_reg(REG_SCALE, 16'd255);
      send_point(coord_t'(CoordMin), 3);
      wait_idle();
   endtask

   // The receiver holds off for a long stretch while points keep coming, so the block
   // fills and stalls its input.
   task automatic test_backpressure();
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      @(posedge clock);
      hold_off_cycles = 150;
      repeat (20) send_point(random_coord(), random_coord());
      wait_idle();
   endtask

   // Random configurations, each followed by a batch of random points, under each mix of
   // sender gaps and receiver stalls.
   task automatic test_random();
      for (int batch = 0; batch < 12; batch++) begin
         case (batch % 4)
            0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_gap_pct = 66; receiver_stall_pct = 0;  end
            2: begin sender_gap_pct = 0;  receiver_stall_pct = 66; end
            default: begin sender_gap_pct = 13; receiver_stall_pct = 13; end
         endcase
         write_reg(REG_MODE, 16'($urandom));
         write_reg(REG_PIVOT_X, 16'($urandom));
         write_reg(REG_PIVOT_Y, 16'($urandom));
         write_reg(REG_SHIFT_X, 16'($urandom));
         write_reg(REG_SHIFT_Y, 16'($urandom));
         write_reg(REG_ANGLE, 16'($urandom));
         write_reg(REG_SCALE, $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(512)));
         write_reg(REG_SPARE, 16'($urandom));
         repeat (60) send_point(random_coord(), random_coord());
         wait_idle();
      end
   endtask

   // Reset, then the tests in turn, then the verdict.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_translate();
      test_spare_index();
      test_rotate();
      test_scale();
      test_backpressure();
      test_random();
      repeat (8) @(posedge clock);
      $display("Covered %0d points and %0d results (%0d saturated) over %0d register writes,",
               points_sent, results_checked, clipped_results, reg_writes);
      $display("in translate, rotate and scale modes under gaps, stalls and a long hold-off.");
      if (mismatches == 0) begin
         $display("point_rotate_scale_pivot verification clean");
      end else begin
         $display("point_rotate_scale_pivot verification failed");
      end
      $finish;
   end

endmodule
